// ===== hw/rtl/dpfb_pkg.sv =====
package dpfb_pkg;

    localparam int MAX_PIXELS  = 1024;
    localparam int COORD_BITS  = 16;
    localparam int PIX_AW      = $clog2(MAX_PIXELS);
    localparam int BORDER_BASE = 12;
    localparam int WORD_DEPTH  = BORDER_BASE + MAX_PIXELS + 1;
    localparam int WORD_AW     = $clog2(WORD_DEPTH);

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // input kinds
    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_POINT = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_LOADED = 3'd0;
    localparam logic [2:0] ST_NODATA = 3'd1;
    localparam logic [2:0] ST_BEHIND = 3'd2;
    localparam logic [2:0] ST_OUTSIDE = 3'd3;
    localparam logic [2:0] ST_INSIDE = 3'd4;
    localparam logic [2:0] ST_REPORT = 3'd5;

    // configuration register indexes
    localparam logic [7:0] CFG_OFFSET  = 8'd0;
    localparam logic [7:0] CFG_BORDERS = 8'd1;

    // sequencer step codes: one multiply each
    typedef logic [4:0] t_op;
    localparam t_op OP_CC   = 5'd0;
    localparam t_op OP_CS   = 5'd1;
    localparam t_op OP_PX   = 5'd2;
    localparam t_op OP_PZ   = 5'd4;
    localparam t_op OP_A0   = 5'd5;
    localparam t_op OP_A2   = 5'd7;
    localparam t_op OP_V0   = 5'd8;
    localparam t_op OP_V2   = 5'd10;
    localparam t_op OP_H0   = 5'd11;
    localparam t_op OP_H2   = 5'd13;
    localparam t_op OP_B0   = 5'd14;
    localparam t_op OP_BL   = 5'd15;
    localparam t_op OP_SCAN = 5'd16;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_MSTART,
        S_MWAIT,
        S_APPLY,
        S_BOXRD,
        S_BOXWR,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] smin;
        logic [COORD_BITS-1:0] smax;
        logic [COORD_BITS-1:0] lmin;
        logic [COORD_BITS-1:0] lmax;
    } t_box;

    localparam t_box BOX_EMPTY = '{hit: 1'b0, smin: {COORD_BITS{1'b1}}, smax: '0,
                                   lmin: {COORD_BITS{1'b1}}, lmax: '0};

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [PIX_AW-1:0] addr;
        t_box              wdata;
    } t_box_req;

endpackage

// ===== hw/rtl/dem_point_footprint_binner.sv =====
// Order: a load, an unused kind or an out-of-range box read answers in the cycle after start;
// an in-range box read answers from the report state. A terrain point runs 14 multiply steps
// (fetch, start, shared multiplier, apply), two border checks, then one step per border
// scanned until the border k is found.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset (synchronous, active low) clears control and then sweeps the 1024 pixel boxes, one
// per cycle, with busy high; results are never stalled by the receiver.
module dem_point_footprint_binner
    import dpfb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [10:0]           i_word_index,
    input  logic signed [63:0]    i_word_value,
    input  logic signed [39:0]    i_radius,
    input  logic                  i_radius_valid,
    input  logic signed [31:0]    i_cos_lat,
    input  logic signed [31:0]    i_sin_lat,
    input  logic signed [31:0]    i_cos_lon,
    input  logic signed [31:0]    i_sin_lon,
    input  logic [15:0]           i_sample,
    input  logic [15:0]           i_line,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_index,
    input  logic [39:0]           i_cfg_data,
    output logic                  o_done,
    output logic [2:0]            o_status,
    output logic [9:0]            o_pixel_index,
    output logic                  o_box_hit,
    output logic [15:0]           o_sample_min,
    output logic [15:0]           o_sample_max,
    output logic [15:0]           o_line_min,
    output logic [15:0]           o_line_max
);

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    t_state r_state, n_state;

    // configuration
    logic signed [39:0] r_offset;
    logic [10:0]        r_bcount;
    logic [10:0]        w_n, w_nlast;

    // latched point
    logic signed [63:0]    r_r, n_r;
    logic signed [31:0]    r_cos_lat, r_sin_lat, r_cos_lon, r_sin_lon;
    logic [COORD_BITS-1:0] r_sample, r_line;

    // sequencer and working values
    t_op                r_op, n_op;
    logic [10:0]        r_k, n_k;
    logic [PIX_AW-1:0]  r_pix, n_pix;
    logic signed [63:0] r_cc, n_cc, r_cs, n_cs, r_acc, n_acc, r_a, n_a;
    logic signed [63:0] r_p [3];
    logic signed [63:0] n_p [3];

    // result registers
    logic       r_o_valid, n_o_valid;
    logic [2:0] r_o_status, n_o_status;
    logic [9:0] r_o_pix, n_o_pix;
    t_box       r_o_box, n_o_box;

    // shared multiplier
    logic                m_start, m_done;
    logic signed [63:0]  m_a, m_b, m_sh;
    logic signed [127:0] m_prod;

    // memories
    logic               wm_wen, wm_ren;
    logic [WORD_AW-1:0] wm_raddr;
    logic [63:0]        wm_rdata;
    t_box_req           bx_req;
    t_box               bx_rdata;
    logic               bx_clearing;

    logic w_accept;

    // apply-step decisions
    logic signed [63:0]  ap_acc, ap_p;
    logic signed [127:0] w_hs;
    logic [64:0]         w_absv, w_lim;
    logic                ap_behind, ap_outside, ap_gt_hs, ap_gt_pr, ap_hit;
    logic [1:0]          w_psel;
    logic [10:0]         w_knext;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // clamp the border count into its usable range
    always_comb begin
        if (r_bcount < 11'd2) begin
            w_n = 11'd2;
        end else if (r_bcount > 11'(MAX_PIXELS + 1)) begin
            w_n = 11'(MAX_PIXELS + 1);
        end else begin
            w_n = r_bcount;
        end
    end
    assign w_nlast = w_n - 11'd1;
    assign w_knext = r_k + 11'd1;

    // which p component goes with the current dot-product step
    always_comb begin
        if (r_op <= OP_A2) begin
            w_psel = 2'(r_op - OP_A0);
        end else if (r_op <= OP_V2) begin
            w_psel = 2'(r_op - OP_V0);
        end else begin
            w_psel = 2'(r_op - OP_H0);
        end
    end

    always_comb begin
        if (r_op == OP_A0 || r_op == OP_V0 || r_op == OP_H0) begin
            ap_acc = m_sh;
        end else begin
            ap_acc = sadd64(r_acc, m_sh);
        end
        ap_p      = ssub64(m_sh, wm_rdata);
        w_hs      = {{32{r_acc[63]}}, r_acc, 32'd0};
        w_lim     = {2'b00, 63'((r_a - 64'sd1) >>> 1)};
        w_absv    = ap_acc[63] ? 65'(-{ap_acc[63], ap_acc}) : {1'b0, ap_acc};
        ap_gt_hs  = (w_hs > m_prod);
        ap_gt_pr  = (m_prod > w_hs);
        ap_behind = (r_op == OP_A2) && (ap_acc <= 64'sd0);
        ap_outside = ((r_op == OP_V2) && (w_absv > w_lim))
                  || ((r_op == OP_B0) && !ap_gt_hs)
                  || ((r_op == OP_BL) && !ap_gt_pr);
        ap_hit    = (r_op == OP_SCAN) && !ap_gt_hs;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (!bx_clearing) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        K_POINT: if (i_radius_valid) n_state = S_MSTART;
                        K_READ:  if (i_word_index < 11'(MAX_PIXELS)) n_state = S_REPORT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH:  n_state = S_MSTART;
            S_MSTART: n_state = S_MWAIT;
            S_MWAIT: begin
                if (m_done) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (ap_behind || ap_outside) begin
                    n_state = S_IDLE;
                end else if (r_op == OP_CC) begin
                    n_state = S_MSTART;
                end else if (r_op <= OP_B0) begin
                    n_state = S_FETCH;
                end else if (r_op == OP_BL) begin
                    n_state = (w_nlast > 11'd1) ? S_FETCH : S_BOXRD;
                end else if (ap_hit) begin
                    n_state = S_BOXRD;
                end else begin
                    n_state = (w_knext < w_nlast) ? S_FETCH : S_BOXRD;
                end
            end
            S_BOXRD:  n_state = S_BOXWR;
            S_BOXWR:  n_state = S_IDLE;
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath, memory requests and results
    always_comb begin
        n_op       = r_op;
        n_k        = r_k;
        n_pix      = r_pix;
        n_r        = r_r;
        n_cc       = r_cc;
        n_cs       = r_cs;
        n_acc      = r_acc;
        n_a        = r_a;
        n_p        = r_p;
        n_o_valid  = 1'b0;
        n_o_status = r_o_status;
        n_o_pix    = r_o_pix;
        n_o_box    = r_o_box;
        m_start    = 1'b0;
        m_a        = '0;
        m_b        = '0;
        wm_wen     = 1'b0;
        wm_ren     = 1'b0;
        wm_raddr   = '0;
        bx_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_o_pix = '0;
                    n_o_box = '0;
                    n_op    = OP_CC;
                    // sign-extend both terms before adding
                    n_r     = 64'(i_radius) + 64'(r_offset);
                    case (i_kind)
                        K_LOAD: begin
                            wm_wen     = (i_word_index < 11'(WORD_DEPTH));
                            n_o_valid  = 1'b1;
                            n_o_status = ST_LOADED;
                        end
                        K_POINT: begin
                            n_o_status = ST_NODATA;
                            n_o_valid  = !i_radius_valid;
                        end
                        K_READ: begin
                            n_o_status  = ST_REPORT;
                            n_o_pix     = i_word_index[9:0];
                            bx_req.rd   = 1'b1;
                            bx_req.addr = i_word_index[PIX_AW-1:0];
                            if (i_word_index >= 11'(MAX_PIXELS)) begin
                                n_o_valid = 1'b1;
                                n_o_box   = BOX_EMPTY;
                            end
                        end
                        default: begin
                            n_o_valid  = 1'b1;
                            n_o_status = ST_LOADED;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                wm_ren = 1'b1;
                if (r_op <= OP_A2) begin
                    wm_raddr = WORD_AW'(r_op - OP_PX);
                end else if (r_op <= OP_V2) begin
                    wm_raddr = WORD_AW'(r_op) + WORD_AW'(1);
                end else if (r_op <= OP_H2) begin
                    wm_raddr = WORD_AW'(r_op) - WORD_AW'(5);
                end else if (r_op == OP_B0) begin
                    wm_raddr = WORD_AW'(BORDER_BASE);
                end else if (r_op == OP_BL) begin
                    wm_raddr = WORD_AW'(BORDER_BASE) + w_nlast;
                end else begin
                    wm_raddr = WORD_AW'(BORDER_BASE) + r_k;
                end
            end
            S_MSTART: begin
                m_start = 1'b1;
                if (r_op == OP_CC) begin
                    m_a = 64'(r_cos_lat);
                    m_b = 64'(r_cos_lon);
                end else if (r_op == OP_CS) begin
                    m_a = 64'(r_cos_lat);
                    m_b = 64'(r_sin_lon);
                end else if (r_op == OP_PX) begin
                    m_a = r_r;
                    m_b = r_cc;
                end else if (r_op < OP_PZ) begin
                    m_a = r_r;
                    m_b = r_cs;
                end else if (r_op == OP_PZ) begin
                    m_a = r_r;
                    m_b = 64'(r_sin_lat);
                end else if (r_op <= OP_H2) begin
                    m_a = wm_rdata;
                    m_b = r_p[w_psel];
                end else begin
                    m_a = wm_rdata;
                    m_b = r_a;
                end
            end
            S_APPLY: begin
                n_op = r_op + 5'd1;
                if (r_op == OP_CC) begin
                    n_cc = m_sh;
                end else if (r_op == OP_CS) begin
                    n_cs = m_sh;
                end else if (r_op <= OP_PZ) begin
                    n_p[2'(r_op - OP_PX)] = ap_p;
                end else if (r_op <= OP_H2) begin
                    n_acc = ap_acc;
                    if (r_op == OP_A2) n_a = ap_acc;
                end else if (r_op == OP_BL) begin
                    n_k   = 11'd1;
                    n_pix = '0;
                end else if (r_op == OP_SCAN) begin
                    n_op = OP_SCAN;
                    n_k  = w_knext;
                    n_pix = ap_hit ? PIX_AW'(r_k - 11'd1) : PIX_AW'(r_k);
                end
                if (ap_behind || ap_outside) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ap_behind ? ST_BEHIND : ST_OUTSIDE;
                end
            end
            S_BOXRD: begin
                bx_req.rd   = 1'b1;
                bx_req.addr = r_pix;
            end
            S_BOXWR: begin
                // widen the box: minimum and maximum each on their own
                bx_req.wr          = 1'b1;
                bx_req.addr        = r_pix;
                bx_req.wdata.hit   = 1'b1;
                bx_req.wdata.smin  = (r_sample < bx_rdata.smin) ? r_sample : bx_rdata.smin;
                bx_req.wdata.smax  = (r_sample > bx_rdata.smax) ? r_sample : bx_rdata.smax;
                bx_req.wdata.lmin  = (r_line < bx_rdata.lmin) ? r_line : bx_rdata.lmin;
                bx_req.wdata.lmax  = (r_line > bx_rdata.lmax) ? r_line : bx_rdata.lmax;
                n_o_valid  = 1'b1;
                n_o_status = ST_INSIDE;
                n_o_pix    = 10'(r_pix);
            end
            S_REPORT: begin
                n_o_valid = 1'b1;
                n_o_box   = bx_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_o_valid <= 1'b0;
            r_offset  <= '0;
            r_bcount  <= 11'd2;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && i_cfg_index == CFG_OFFSET) r_offset <= i_cfg_data;
            if (i_cfg_valid && i_cfg_index == CFG_BORDERS) r_bcount <= i_cfg_data[10:0];
        end
    end

    // payload registers: hold inputs of the accepted request, advance work values
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cos_lat <= i_cos_lat;
            r_sin_lat <= i_sin_lat;
            r_cos_lon <= i_cos_lon;
            r_sin_lon <= i_sin_lon;
            r_sample  <= i_sample[COORD_BITS-1:0];
            r_line    <= i_line[COORD_BITS-1:0];
        end
        r_r        <= n_r;
        r_op       <= n_op;
        r_k        <= n_k;
        r_pix      <= n_pix;
        r_cc       <= n_cc;
        r_cs       <= n_cs;
        r_acc      <= n_acc;
        r_a        <= n_a;
        r_p        <= n_p;
        r_o_status <= n_o_status;
        r_o_pix    <= n_o_pix;
        r_o_box    <= n_o_box;
    end

    dpfb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (m_done),
        .o_prod  (m_prod),
        .o_sh    (m_sh)
    );

    dpfb_wmem u_wmem (
        .i_clk   (i_clk),
        .i_wen   (wm_wen),
        .i_waddr (i_word_index),
        .i_wdata (i_word_value),
        .i_ren   (wm_ren),
        .i_raddr (wm_raddr),
        .o_rdata (wm_rdata)
    );

    dpfb_box u_box (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (bx_req),
        .o_rdata    (bx_rdata),
        .o_clearing (bx_clearing)
    );

    assign o_done        = r_o_valid;
    assign o_status      = r_o_status;
    assign o_pixel_index = r_o_pix;
    assign o_box_hit     = r_o_box.hit;
    assign o_sample_min  = r_o_box.smin;
    assign o_sample_max  = r_o_box.smax;
    assign o_line_min    = r_o_box.lmin;
    assign o_line_max    = r_o_box.lmax;

endmodule

// ===== hw/rtl/dpfb_mul.sv =====
module dpfb_mul
    import dpfb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    output logic                o_done,
    output logic signed [127:0] o_prod,
    output logic signed [63:0]  o_sh
);

    logic         r_busy, r_done, r_neg;
    logic [2:0]   r_cnt;
    logic [63:0]  r_ua, r_ub, r_pp;
    logic [1:0]   r_pshc;
    logic [127:0] r_acc, r_prod;
    logic [31:0]  w_x, w_y;
    logic [1:0]   w_code;
    logic [6:0]   w_shamt;

    // pick the 32x32 partial product for this step
    always_comb begin
        case (r_cnt)
            3'd0: begin w_x = r_ua[31:0];  w_y = r_ub[31:0];  w_code = 2'd0; end
            3'd1: begin w_x = r_ua[31:0];  w_y = r_ub[63:32]; w_code = 2'd1; end
            3'd2: begin w_x = r_ua[63:32]; w_y = r_ub[31:0];  w_code = 2'd1; end
            3'd3: begin w_x = r_ua[63:32]; w_y = r_ub[63:32]; w_code = 2'd2; end
            default: begin w_x = '0; w_y = '0; w_code = 2'd0; end
        endcase
    end

    assign w_shamt = {r_pshc, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_pp   <= 64'(w_x * w_y);
                r_pshc <= w_code;
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + ({64'd0, r_pp} << w_shamt);
            end
            if (r_cnt == 3'd5) begin
                r_prod <= r_neg ? 128'(-r_acc) : r_acc;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
    // floor shift by 30, saturate to 64 bits
    assign o_sh = ((&r_prod[127:93]) || !(|r_prod[127:93])) ? r_prod[93:30]
                : (r_prod[127] ? S64_MIN : S64_MAX);

endmodule

// ===== hw/rtl/dpfb_wmem.sv =====
module dpfb_wmem
    import dpfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_wen,
    input  logic [WORD_AW-1:0] i_waddr,
    input  logic [63:0]        i_wdata,
    input  logic               i_ren,
    input  logic [WORD_AW-1:0] i_raddr,
    output logic [63:0]        o_rdata
);

    logic [63:0] r_mem [WORD_DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dpfb_box.sv =====
module dpfb_box
    import dpfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_box_req i_req,
    output t_box     o_rdata,
    output logic     o_clearing
);

    t_box              r_mem [MAX_PIXELS];
    t_box              r_rdata;
    logic              r_clr;
    logic [PIX_AW-1:0] r_ccnt;

    // sweep every entry to empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_ccnt <= '0;
        end else if (r_clr) begin
            r_ccnt <= r_ccnt + 1'b1;
            if (r_ccnt == PIX_AW'(MAX_PIXELS - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_ccnt] <= BOX_EMPTY;
        end else if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import dpfb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // kind 3 has no code in the package; the block must treat it as a no-op
    localparam logic [1:0] K_UNUSED = 2'd3;
    // cycles without any accepted request, result or register write before giving up;
    // the limit covers the box sweep after reset and the longest point here
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 370;
    localparam longint Q30 = 64'sd1073741824;
    localparam longint Q16 = 64'sd65536;

    typedef struct {
        logic [1:0]         kind;
        logic [10:0]        widx;
        logic signed [63:0] wval;
        logic signed [39:0] radius;
        logic               rvalid;
        logic signed [31:0] clat;
        logic signed [31:0] slat;
        logic signed [31:0] clon;
        logic signed [31:0] slon;
        logic [15:0]        smp;
        logic [15:0]        ln;
    } bin_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  pix;
        logic        hit;
        logic [15:0] smin;
        logic [15:0] smax;
        logic [15:0] lmin;
        logic [15:0] lmax;
    } bin_res_t;

    // Predicts the binner and holds the results it still owes.
    class footprint_board;
        logic signed [63:0] offset;
        logic [10:0]        nborders;
        logic signed [63:0] cam [12];
        logic signed [63:0] brd [MAX_PIXELS + 1];
        t_box               boxes [MAX_PIXELS];
        bin_res_t           owed [$];
        int                 errors;

        function new();
            offset = 0;
            nborders = 2;
            errors = 0;
            foreach (cam[i]) cam[i] = 0;
            foreach (brd[i]) brd[i] = 0;
            foreach (boxes[i]) boxes[i] = BOX_EMPTY;
        endfunction

        function void write_reg(logic [7:0] idx, logic [39:0] d);
            if (idx == CFG_OFFSET) offset = $signed(d);
            else if (idx == CFG_BORDERS) nborders = d[10:0];
        endfunction

        function logic signed [63:0] sat64(logic signed [127:0] x);
            logic signed [127:0] mx;
            logic signed [127:0] mn;
            mx = S64_MAX;
            mn = S64_MIN;
            if (x > mx) return S64_MAX;
            if (x < mn) return S64_MIN;
            return x[63:0];
        endfunction

        function logic signed [127:0] wide_mul(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [127:0] wa;
            logic signed [127:0] wb;
            wa = a;
            wb = b;
            return wa * wb;
        endfunction

        function logic signed [63:0] mul_q30(logic signed [63:0] a, logic signed [63:0] b);
            return sat64(wide_mul(a, b) >>> 30);
        endfunction

        function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [127:0] wa;
            logic signed [127:0] wb;
            wa = a;
            wb = b;
            return sat64(wa + wb);
        endfunction

        function logic signed [63:0] project(int base, logic signed [63:0] p0,
                                             logic signed [63:0] p1, logic signed [63:0] p2);
            logic signed [63:0] s;
            s = mul_q30(cam[base], p0);
            s = add_sat(s, mul_q30(cam[base + 1], p1));
            return add_sat(s, mul_q30(cam[base + 2], p2));
        endfunction

        function logic [2:0] classify(bin_req_t q, output int pix);
            logic signed [63:0]  r, p0, p1, p2, a, h, v;
            logic signed [127:0] wa, wv, lim, hs;
            int n, k;
            pix = 0;
            if (!q.rvalid) return ST_NODATA;
            r = q.radius;
            r = r + offset;
            // subtract the camera centre, saturating
            wa = mul_q30(r, mul_q30(q.clat, q.clon));
            p0 = sat64(wa - cam[0]);
            wa = mul_q30(r, mul_q30(q.clat, q.slon));
            p1 = sat64(wa - cam[1]);
            wa = mul_q30(r, q.slat);
            p2 = sat64(wa - cam[2]);
            a = project(3, p0, p1, p2);
            if (a <= 0) return ST_BEHIND;
            v = project(9, p0, p1, p2);
            wa = a;
            wv = v;
            lim = (wa - 1) >>> 1;
            if (wv > lim || -wv > lim) return ST_OUTSIDE;
            h = project(6, p0, p1, p2);
            n = int'(nborders);
            if (n < 2) n = 2;
            if (n > MAX_PIXELS + 1) n = MAX_PIXELS + 1;
            hs = h;
            hs = hs <<< 32;
            if (!(hs > wide_mul(brd[0], a))) return ST_OUTSIDE;
            if (!(wide_mul(brd[n - 1], a) > hs)) return ST_OUTSIDE;
            for (k = 1; k < n - 1; k++)
                if (!(hs > wide_mul(brd[k], a))) break;
            pix = k - 1;
            return ST_INSIDE;
        endfunction

        function void note_request(bin_req_t q);
            bin_res_t e;
            int pix;
            e = '0;
            case (q.kind)
                K_LOAD: begin
                    if (q.widx < BORDER_BASE) cam[q.widx] = q.wval;
                    else if (q.widx < WORD_DEPTH) brd[q.widx - BORDER_BASE] = q.wval;
                    e.status = ST_LOADED;
                end
                K_POINT: begin
                    e.status = classify(q, pix);
                    if (e.status == ST_INSIDE) begin
                        boxes[pix].hit = 1'b1;
                        if (q.smp < boxes[pix].smin) boxes[pix].smin = q.smp;
                        if (q.smp > boxes[pix].smax) boxes[pix].smax = q.smp;
                        if (q.ln < boxes[pix].lmin) boxes[pix].lmin = q.ln;
                        if (q.ln > boxes[pix].lmax) boxes[pix].lmax = q.ln;
                        e.pix = 10'(pix);
                    end
                end
                K_READ: begin
                    e.status = ST_REPORT;
                    e.pix = q.widx[9:0];
                    if (q.widx < MAX_PIXELS) begin
                        e.hit = boxes[q.widx].hit;
                        e.smin = boxes[q.widx].smin;
                        e.smax = boxes[q.widx].smax;
                        e.lmin = boxes[q.widx].lmin;
                        e.lmax = boxes[q.widx].lmax;
                    end else begin
                        e.smin = '1;
                        e.lmin = '1;
                    end
                end
                default: e.status = ST_LOADED;
            endcase
            owed.push_back(e);
        endfunction

        function void check_result(bin_res_t got);
            bin_res_t e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d pix %0d", got.status, got.pix);
                return;
            end
            e = owed.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp st %0d pix %0d hit %0d s %h-%h l %h-%h, ",
                              "got st %0d pix %0d hit %0d s %h-%h l %h-%h"},
                             e.status, e.pix, e.hit, e.smin, e.smax, e.lmin, e.lmax,
                             got.status, got.pix, got.hit, got.smin, got.smax,
                             got.lmin, got.lmax);
            end
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_kind;
    logic [10:0]        i_word_index;
    logic signed [63:0] i_word_value;
    logic signed [39:0] i_radius;
    logic               i_radius_valid;
    logic signed [31:0] i_cos_lat;
    logic signed [31:0] i_sin_lat;
    logic signed [31:0] i_cos_lon;
    logic signed [31:0] i_sin_lon;
    logic [15:0]        i_sample;
    logic [15:0]        i_line;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index;
    logic [39:0]        i_cfg_data;
    logic               o_done;
    logic [2:0]         o_status;
    logic [9:0]         o_pixel_index;
    logic               o_box_hit;
    logic [15:0]        o_sample_min;
    logic [15:0]        o_sample_max;
    logic [15:0]        o_line_min;
    logic [15:0]        o_line_max;

    footprint_board sb = new();
    bit start_hi = 0;
    int idle_cycles = 0;
    int random_items = 0;

    dem_point_footprint_binner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_word_index  (i_word_index),
        .i_word_value  (i_word_value),
        .i_radius      (i_radius),
        .i_radius_valid(i_radius_valid),
        .i_cos_lat     (i_cos_lat),
        .i_sin_lat     (i_sin_lat),
        .i_cos_lon     (i_cos_lon),
        .i_sin_lon     (i_sin_lon),
        .i_sample      (i_sample),
        .i_line        (i_line),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_pixel_index (o_pixel_index),
        .o_box_hit     (o_box_hit),
        .o_sample_min  (o_sample_min),
        .o_sample_max  (o_sample_max),
        .o_line_min    (o_line_min),
        .o_line_max    (o_line_max)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Results cannot be held off: check every strobe at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_result({o_status, o_pixel_index, o_box_hit, o_sample_min,
                             o_sample_max, o_line_min, o_line_max});
    end

    // Watchdog: any accepted request, result or register write restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done === 1'b1 || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        logic [63:0] u;
        logic [63:0] span;
        u = rand64();
        span = hi - lo + 1;
        return lo + longint'(u % span);
    endfunction

    function automatic bin_req_t load_req(int idx, longint val);
        bin_req_t q = '{default: '0};
        q.kind = K_LOAD;
        q.widx = 11'(idx);
        q.wval = val;
        return q;
    endfunction

    function automatic bin_req_t read_req(int idx);
        bin_req_t q = '{default: '0};
        q.kind = K_READ;
        q.widx = 11'(idx);
        return q;
    endfunction

    function automatic bin_req_t point_req(longint r, bit rv, longint clat, longint slat,
                                           longint clon, longint slon, int smp, int ln);
        bin_req_t q = '{default: '0};
        q.kind = K_POINT;
        q.radius = 40'(r);
        q.rvalid = rv;
        q.clat = 32'(clat);
        q.slat = 32'(slat);
        q.clon = 32'(clon);
        q.slon = 32'(slon);
        q.smp = 16'(smp);
        q.ln = 16'(ln);
        return q;
    endfunction

    // Point aimed into the camera's field of view with random content;
    // a share of them fall outside in either direction.
    function automatic bin_req_t aimed_point();
        longint slat_span;
        slat_span = ($urandom_range(0, 4) == 0) ? Q30 / 2 : Q30 / 16;
        return point_req(rand_between(Q16 * 10000, Q16 * 64'sd4194304),
                         $urandom_range(0, 19) != 0,
                         rand_between(Q30 / 2, Q30), rand_between(-slat_span, slat_span),
                         rand_between(Q30 / 4, Q30), rand_between(-Q30 / 2, Q30 / 2),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
    endfunction

    function automatic bin_req_t noise_req();
        bin_req_t q;
        q.kind = 2'($urandom_range(0, 3));
        q.widx = 11'($urandom_range(0, WORD_DEPTH - 1));
        q.wval = rand64();
        q.radius = 40'(rand64());
        q.rvalid = 1'($urandom_range(0, 1));
        q.clat = 32'(rand_between(-Q30, Q30));
        q.slat = 32'(rand_between(-Q30, Q30));
        q.clon = 32'(rand_between(-Q30, Q30));
        q.slon = 32'(rand_between(-Q30, Q30));
        q.smp = 16'($urandom);
        q.ln = 16'($urandom);
        return q;
    endfunction

    // Drop start unless the next request follows back to back.
    task automatic release_start();
        if (start_hi) begin
            start <= 1'b0;
            start_hi = 0;
        end
    endtask

    // Present one request after a gap and hold it until the block takes it.
    task automatic send(bin_req_t q, int gap);
        if (gap > 0) release_start();
        repeat (gap) @(posedge i_clk);
        start          <= 1'b1;
        start_hi        = 1;
        i_kind         <= q.kind;
        i_word_index   <= q.widx;
        i_word_value   <= q.wval;
        i_radius       <= q.radius;
        i_radius_valid <= q.rvalid;
        i_cos_lat      <= q.clat;
        i_sin_lat      <= q.slat;
        i_cos_lon      <= q.clon;
        i_sin_lon      <= q.slon;
        i_sample       <= q.smp;
        i_line         <= q.ln;
        do @(posedge i_clk); while (busy);
        sb.note_request(q);
    endtask

    task automatic wait_drained();
        release_start();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Registers change only with the block idle: drain, settle, then write.
    task automatic write_reg(logic [7:0] idx, logic [39:0] d);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, d);
    endtask

    // Camera looking down +x: h/a is y/x and v/a is z/x, optionally tilted and shifted.
    task automatic load_camera(bit perturb, bit nogap);
        longint w [12];
        w = '{0, 0, 0, Q30, 0, 0, 0, Q30, 0, 0, 0, Q30};
        if (perturb) begin
            for (int i = 0; i < 3; i++) w[i] = rand_between(-Q16 * 100, Q16 * 100);
            for (int i = 3; i < 12; i++) w[i] += rand_between(-Q30 / 64, Q30 / 64);
        end
        for (int i = 0; i < 12; i++) send(load_req(i, w[i]), nogap ? 0 : $urandom_range(0, 4));
    endtask

    // Sorted borders across -0.6..0.6 in Q.32 with optional jitter.
    task automatic load_borders(int n, bit jitter, bit nogap);
        longint lo, step, pos;
        lo = -64'sd2576980378;
        step = (2 * 64'sd2576980378) / (n - 1);
        for (int i = 0; i < n; i++) begin
            pos = lo + i * step;
            if (jitter && step > 8) pos += rand_between(-step / 4, step / 4);
            send(load_req(BORDER_BASE + i, pos), nogap ? 0 : $urandom_range(0, 4));
        end
    endtask

    initial begin
        bin_req_t q;
        int nb, cnt, pick;
        bit nogap;
        logic [39:0] ofs;

        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_kind         = K_LOAD;
        i_word_index   = '0;
        i_word_value   = '0;
        i_radius       = '0;
        i_radius_valid = 1'b0;
        i_cos_lat      = '0;
        i_sin_lat      = '0;
        i_cos_lon      = '0;
        i_sin_lon      = '0;
        i_sample       = '0;
        i_line         = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every camera word and every border in use is written before any point reads it.
        load_camera(0, 0);

        // Directed part: four borders at -0.6, -0.2, 0.2, 0.6.
        write_reg(CFG_BORDERS, 40'd4);
        load_borders(4, 0, 0);
        send(point_req(64'sh7F_FFFF_FFFF, 0, Q30, Q30, Q30, Q30, 65535, 65535), 0);
        send(point_req(Q16 * 1000, 1, Q30, 0, Q30, 0, 0, 0), 1);
        send(point_req(Q16 * 1000, 1, Q30, 0, Q30, 0, 65535, 65535), 0);
        send(read_req(1), 2);
        send(read_req(0), 0);
        // behind the camera, by direction and by negative radius
        send(point_req(Q16 * 1000, 1, Q30, 0, -Q30, 0, 5, 5), 0);
        send(point_req(-64'sh80_0000_0000, 1, -Q30, -Q30, -Q30, -Q30, 7, 7), 3);
        // outside vertically, then horizontally
        send(point_req(Q16 * 1000, 1, Q30 * 6 / 10, Q30 * 8 / 10, Q30, 0, 1, 1), 0);
        send(point_req(Q16 * 1000, 1, Q30, 0, Q30 / 4, Q30, 1, 1), 0);
        // box reads past the pixel range, unused kind, load past the table
        send(read_req(MAX_PIXELS), 0);
        send(read_req(WORD_DEPTH - 1), 4);
        q = noise_req();
        q.kind = K_UNUSED;
        send(q, 0);
        send(load_req(2047, -1), 0);
        // unsorted borders resolve to the first bracket
        send(load_req(BORDER_BASE + 1, 64'sd1717986918), 0);
        send(point_req(Q16 * 1000, 1, Q30, 0, Q30, Q30 * 3 / 10, 100, 200), 0);
        send(read_req(0), 0);
        load_borders(4, 0, 0);
        // saturating centre subtraction
        send(load_req(0, S64_MIN), 0);
        send(point_req(64'sh7F_FFFF_FFFF, 1, Q30, 0, Q30, 0, 9, 9), 0);
        send(load_req(0, 0), 0);

        // Register extremes, including an ignored index and clamped border counts.
        write_reg(CFG_OFFSET, 40'h80_0000_0000);
        send(point_req(64'sh7F_FFFF_FFFF, 1, Q30, 0, Q30, 0, 3, 3), 0);
        write_reg(CFG_OFFSET, 40'h7F_FFFF_FFFF);
        send(point_req(64'sh7F_FFFF_FFFF, 1, Q30, 0, Q30, 0, 3, 3), 0);
        write_reg(8'd5, 40'hFF_FFFF_FFFF);
        write_reg(CFG_BORDERS, 40'd0);
        send(point_req(Q16 * 1000, 1, Q30, 0, Q30, 0, 4, 4), 0);
        write_reg(CFG_OFFSET, 40'd0);

        // Border count past the table clamps to the last border; the second border
        // closes the range so only the first two and the last are ever read.
        write_reg(CFG_BORDERS, 40'd2047);
        send(load_req(BORDER_BASE, -64'sd2576980378), 0);
        send(load_req(BORDER_BASE + 1, 64'sd2576980378), 0);
        send(load_req(BORDER_BASE + MAX_PIXELS, 64'sd2576980378), 0);
        send(point_req(Q16 * 1000, 1, Q30, 0, Q30, 0, 11, 12), 0);
        send(point_req(Q16 * 1000, 1, Q30, 0, Q30 / 4, Q30, 1, 1), 0);
        send(read_req(0), 0);

        // Random scenes: configure, reload the model, then mostly aimed points.
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            nb = (pick == 0) ? 2 : $urandom_range(3, 24);
            pick = $urandom_range(0, 9);
            if (pick == 0) ofs = 40'h80_0000_0000;
            else if (pick == 1) ofs = 40'h7F_FFFF_FFFF;
            else ofs = 40'(rand_between(-Q16 * 500, Q16 * 500));
            write_reg(CFG_OFFSET, ofs);
            write_reg(CFG_BORDERS, 40'(nb));
            nogap = ($urandom_range(0, 3) == 0);
            load_camera($urandom_range(0, 1), nogap);
            load_borders(nb, 1, nogap);
            cnt = $urandom_range(20, 40);
            for (int i = 0; i < cnt; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) q = aimed_point();
                else if (pick == 7) q = read_req($urandom_range(0, 1) ?
                                                 $urandom_range(0, nb - 2) :
                                                 $urandom_range(0, WORD_DEPTH - 1));
                else q = noise_req();
                send(q, nogap ? 0 : $urandom_range(0, 4));
                random_items++;
            end
        end

        // Drain, let the block settle, then judge.
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
